/* hdl/c2p_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants for the cartesian_to_polar CORDIC pipeline.
// No dependencies; used by every module of the block.
package c2p_pkg;

    localparam int ITERATIONS  = 16;
    localparam int COORD_WIDTH = 16;

    localparam int GUARD_BITS = 14;
    localparam int ANGLE_FRAC = 24;
    localparam int MAX_ITER   = 24;
    localparam int NUM_ROT    = (ITERATIONS < MAX_ITER) ? ITERATIONS : MAX_ITER;

    localparam int OUT_W = 16;
    // sqrt(2) growth, CORDIC gain and sign on top of the guarded coordinate
    localparam int XW = COORD_WIDTH + GUARD_BITS + 3;
    localparam int ZW = ANGLE_FRAC + 3;

    localparam int GAIN_W    = 24;
    localparam int HI_W      = XW - 1 - 16;
    localparam int PROD_HI_W = HI_W + GAIN_W;
    localparam int PROD_LO_W = 16 + GAIN_W;
    localparam int MAG_SHIFT = GUARD_BITS + ANGLE_FRAC - 16;
    localparam int MW        = PROD_HI_W + 1 - MAG_SHIFT;
    localparam int PH_SHIFT  = ANGLE_FRAC - 13;
    localparam int PW        = ZW + 1 - PH_SHIFT;

    typedef logic signed [XW-1:0] coord_t;
    typedef logic signed [ZW-1:0] angle_t;

    localparam angle_t HALF_PI_FX = angle_t'(26353589);
    localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(10188014);
    localparam logic signed [OUT_W-1:0] PI_PHASE = OUT_W'(25736);
    localparam logic signed [PW-1:0] PH_LIMIT = PW'(25736);
    localparam logic [OUT_W-1:0] MAG_MAX = '1;

    typedef struct packed {
        coord_t                  x;
        coord_t                  y;
        angle_t                  z;
        logic                    bypass;       // point on the x axis, result already known
        logic [OUT_W-1:0]        bypass_mag;
        logic signed [OUT_W-1:0] bypass_phase;
    } vec_t;

    typedef struct packed {
        logic [OUT_W-1:0]        magnitude;
        logic signed [OUT_W-1:0] phase;
    } res_t;

    // atan(2^-i) * 2^24, rounded
    function automatic angle_t atan_entry(input int idx);
        angle_t val;
        begin
            case (idx)
                0:       val = angle_t'(13176795);
                1:       val = angle_t'(7778716);
                2:       val = angle_t'(4110060);
                3:       val = angle_t'(2086331);
                4:       val = angle_t'(1047214);
                5:       val = angle_t'(524117);
                6:       val = angle_t'(262123);
                7:       val = angle_t'(131069);
                8:       val = angle_t'(65536);
                9:       val = angle_t'(32768);
                10:      val = angle_t'(16384);
                11:      val = angle_t'(8192);
                12:      val = angle_t'(4096);
                13:      val = angle_t'(2048);
                14:      val = angle_t'(1024);
                15:      val = angle_t'(512);
                16:      val = angle_t'(256);
                17:      val = angle_t'(128);
                18:      val = angle_t'(64);
                19:      val = angle_t'(32);
                20:      val = angle_t'(16);
                21:      val = angle_t'(8);
                22:      val = angle_t'(4);
                23:      val = angle_t'(2);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

/* hdl/cartesian_to_polar.sv */
`timescale 1ns / 1ps
// Cartesian to polar converter (CORDIC vectoring mode), top level.
// Pipeline: 1 input stage, one stage per micro-rotation (16) and 2 gain/rounding
// stages; one point per cycle while point_stall is low.
// A one-entry skid register on the output keeps point_stall a registered signal.
// Reset clears only the valid bits of the pipeline and of the skid register.
module cartesian_to_polar
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  logic signed [c2p_pkg::OUT_W-1:0]    x_coord,
    input  logic signed [c2p_pkg::OUT_W-1:0]    y_coord,
    output logic                                polar_valid,
    input  logic                                polar_stall,
    output logic [c2p_pkg::OUT_W-1:0]           magnitude,
    output logic signed [c2p_pkg::OUT_W-1:0]    phase
);

    logic           en;
    logic           pre_valid;
    c2p_pkg::vec_t  pre_vec;
    logic           rot_valid;
    c2p_pkg::vec_t  rot_vec;
    logic           pipe_valid;
    c2p_pkg::res_t  pipe_res;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    c2p_pkg::res_t  skid_reg;

    // whole pipeline holds while the skid register is occupied
    assign en          = !skid_valid_reg;
    assign point_stall = skid_valid_reg;

    c2p_prerot u_prerot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (point_valid),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (pre_valid),
        .out_vec   (pre_vec)
    );

    c2p_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .in_vec    (pre_vec),
        .out_valid (rot_valid),
        .out_vec   (rot_vec)
    );

    c2p_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_vec    (rot_vec),
        .out_valid (pipe_valid),
        .out_res   (pipe_res)
    );

    always_comb
    begin
        if (skid_valid_reg)
            skid_valid_next = polar_stall;
        else
            skid_valid_next = pipe_valid && polar_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    // capture the stalled result as the pipeline moves on
    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
            skid_reg <= pipe_res;
    end

    assign polar_valid = skid_valid_reg || pipe_valid;
    assign magnitude   = skid_valid_reg ? skid_reg.magnitude : pipe_res.magnitude;
    assign phase       = skid_valid_reg ? skid_reg.phase : pipe_res.phase;

endmodule

/* hdl/c2p_prerot.sv */
`timescale 1ns / 1ps
// Input stage: sign extension, x-axis detection and +-pi/2 pre-rotation.
// Depends on c2p_pkg.
module c2p_prerot
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [c2p_pkg::OUT_W-1:0]    x_coord,
    input  logic signed [c2p_pkg::OUT_W-1:0]    y_coord,
    output logic                                out_valid,
    output c2p_pkg::vec_t                       out_vec
);

    logic [31:0]                          x_raw;
    logic [31:0]                          y_raw;
    logic signed [c2p_pkg::COORD_WIDTH-1:0] x_s;
    logic signed [c2p_pkg::COORD_WIDTH-1:0] y_s;
    c2p_pkg::coord_t                      x_e;
    c2p_pkg::coord_t                      y_e;
    c2p_pkg::coord_t                      x_abs;
    c2p_pkg::vec_t                        vec_next;
    c2p_pkg::vec_t                        vec_reg;
    logic                                 valid_reg;

    always_comb
    begin
        x_raw = {16'd0, x_coord};
        y_raw = {16'd0, y_coord};
        x_s   = x_raw[c2p_pkg::COORD_WIDTH-1:0];
        y_s   = y_raw[c2p_pkg::COORD_WIDTH-1:0];
        x_e   = c2p_pkg::coord_t'(x_s);
        y_e   = c2p_pkg::coord_t'(y_s);
        x_abs = x_e[c2p_pkg::XW-1] ? -x_e : x_e;

        vec_next.bypass       = (y_e == '0);
        vec_next.bypass_mag   = (x_abs > c2p_pkg::coord_t'(65535)) ? c2p_pkg::MAG_MAX
                                                                    : x_abs[15:0];
        vec_next.bypass_phase = x_e[c2p_pkg::XW-1] ? c2p_pkg::PI_PHASE : '0;

        if (x_e[c2p_pkg::XW-1])
        begin
            if (!y_e[c2p_pkg::XW-1])
            begin
                vec_next.x = y_e <<< c2p_pkg::GUARD_BITS;
                vec_next.y = (-x_e) <<< c2p_pkg::GUARD_BITS;
                vec_next.z = c2p_pkg::HALF_PI_FX;
            end
            else
            begin
                vec_next.x = (-y_e) <<< c2p_pkg::GUARD_BITS;
                vec_next.y = x_e <<< c2p_pkg::GUARD_BITS;
                vec_next.z = -c2p_pkg::HALF_PI_FX;
            end
        end
        else
        begin
            vec_next.x = x_e <<< c2p_pkg::GUARD_BITS;
            vec_next.y = y_e <<< c2p_pkg::GUARD_BITS;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

/* hdl/c2p_cordic.sv */
`timescale 1ns / 1ps
// Vectoring-mode CORDIC: one registered micro-rotation per stage.
// Depends on c2p_pkg.
module c2p_cordic
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  c2p_pkg::vec_t   in_vec,
    output logic            out_valid,
    output c2p_pkg::vec_t   out_vec
);

    c2p_pkg::vec_t                    stage_reg  [c2p_pkg::NUM_ROT];
    c2p_pkg::vec_t                    stage_next [c2p_pkg::NUM_ROT];
    logic [c2p_pkg::NUM_ROT-1:0]      valid_reg;

    for (genvar i = 0; i < c2p_pkg::NUM_ROT; i++)
    begin : g_rot
        c2p_pkg::vec_t   src;
        logic            src_valid;
        c2p_pkg::coord_t xs;
        c2p_pkg::coord_t ys;

        if (i == 0)
        begin : g_first
            assign src       = in_vec;
            assign src_valid = in_valid;
        end
        else
        begin : g_chain
            assign src       = stage_reg[i-1];
            assign src_valid = valid_reg[i-1];
        end

        always_comb
        begin
            xs            = src.x >>> i;
            ys            = src.y >>> i;
            stage_next[i] = src;
            // rotate toward y = 0
            if (!src.y[c2p_pkg::XW-1])
            begin
                stage_next[i].x = src.x + ys;
                stage_next[i].y = src.y - xs;
                stage_next[i].z = src.z + c2p_pkg::atan_entry(i);
            end
            else
            begin
                stage_next[i].x = src.x - ys;
                stage_next[i].y = src.y + xs;
                stage_next[i].z = src.z - c2p_pkg::atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stage_reg[i] <= stage_next[i];
        end
    end

    assign out_valid = valid_reg[c2p_pkg::NUM_ROT-1];
    assign out_vec   = stage_reg[c2p_pkg::NUM_ROT-1];

endmodule

/* hdl/c2p_post.sv */
`timescale 1ns / 1ps
// Output stages: gain correction multiply, magnitude/phase rounding and clamping.
// Depends on c2p_pkg.
module c2p_post
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  c2p_pkg::vec_t   in_vec,
    output logic            out_valid,
    output c2p_pkg::res_t   out_res
);

    // first stage: two partial products of x * inverse gain
    logic [c2p_pkg::XW-2:0]                 ux;
    logic [c2p_pkg::PROD_HI_W-1:0]          hi_prod_next;
    logic [c2p_pkg::PROD_LO_W-1:0]          lo_prod_next;
    logic signed [c2p_pkg::ZW:0]            z_rnd;
    logic signed [c2p_pkg::PW-1:0]          ph_full;
    logic signed [c2p_pkg::OUT_W-1:0]       phase_next;

    logic [c2p_pkg::PROD_HI_W-1:0]          hi_prod_reg;
    logic [c2p_pkg::PROD_LO_W-1:0]          lo_prod_reg;
    logic signed [c2p_pkg::OUT_W-1:0]       phase_reg;
    logic                                   bypass_reg;
    logic [c2p_pkg::OUT_W-1:0]              bypass_mag_reg;
    logic signed [c2p_pkg::OUT_W-1:0]       bypass_phase_reg;
    logic                                   valid_a_reg;

    // second stage: sum, round, saturate
    logic [c2p_pkg::PROD_HI_W:0]            p_sum;
    logic [c2p_pkg::PROD_HI_W:0]            p_rnd;
    logic [c2p_pkg::MW-1:0]                 mag_full;
    logic [63:0]                            mag_wide;
    c2p_pkg::res_t                          res_next;
    c2p_pkg::res_t                          res_reg;
    logic                                   valid_b_reg;

    always_comb
    begin
        ux = (!in_vec.x[c2p_pkg::XW-1] && (in_vec.x != '0)) ? in_vec.x[c2p_pkg::XW-2:0] : '0;
        hi_prod_next = {{c2p_pkg::GAIN_W{1'b0}}, ux[c2p_pkg::XW-2:16]}
                     * {{c2p_pkg::HI_W{1'b0}}, c2p_pkg::INV_GAIN};
        lo_prod_next = {{c2p_pkg::GAIN_W{1'b0}}, ux[15:0]}
                     * {16'd0, c2p_pkg::INV_GAIN};

        z_rnd   = {in_vec.z[c2p_pkg::ZW-1], in_vec.z}
                + {{(c2p_pkg::ZW + 1 - c2p_pkg::PH_SHIFT){1'b0}}, 1'b1,
                   {(c2p_pkg::PH_SHIFT - 1){1'b0}}};
        ph_full = z_rnd[c2p_pkg::ZW:c2p_pkg::PH_SHIFT];
        if (ph_full > c2p_pkg::PH_LIMIT)
            phase_next = c2p_pkg::PI_PHASE;
        else if (ph_full < -c2p_pkg::PH_LIMIT)
            phase_next = -c2p_pkg::PI_PHASE;
        else
            phase_next = ph_full[c2p_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_prod_reg      <= hi_prod_next;
            lo_prod_reg      <= lo_prod_next;
            phase_reg        <= phase_next;
            bypass_reg       <= in_vec.bypass;
            bypass_mag_reg   <= in_vec.bypass_mag;
            bypass_phase_reg <= in_vec.bypass_phase;
            res_reg          <= res_next;
        end
    end

    always_comb
    begin
        p_sum = {1'b0, hi_prod_reg}
              + {{(c2p_pkg::PROD_HI_W + 1 - (c2p_pkg::PROD_LO_W - 16)){1'b0}},
                 lo_prod_reg[c2p_pkg::PROD_LO_W-1:16]};
        p_rnd = p_sum
              + {{(c2p_pkg::PROD_HI_W + 1 - c2p_pkg::MAG_SHIFT){1'b0}}, 1'b1,
                 {(c2p_pkg::MAG_SHIFT - 1){1'b0}}};
        mag_full = p_rnd[c2p_pkg::PROD_HI_W:c2p_pkg::MAG_SHIFT];
        mag_wide = 64'(mag_full);

        if (bypass_reg)
        begin
            res_next.magnitude = bypass_mag_reg;
            res_next.phase     = bypass_phase_reg;
        end
        else
        begin
            res_next.magnitude = (mag_wide > 64'd65535) ? c2p_pkg::MAG_MAX
                                                         : mag_wide[15:0];
            res_next.phase     = phase_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_res   = res_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for cartesian_to_polar: x/y points in, magnitude/phase out.
// Depends on c2p_pkg and the cartesian_to_polar RTL; predicts every result in-line.
module testbench;

    localparam int    RST_CYCLES = 11;
    localparam int    TAIL_CYCLES = 40;     // well past the pipeline depth
    localparam int    RANDOM_POINTS = 1800;
    localparam longint TIMEOUT_NS = 4_000_000;

    localparam int     FRAC_GUARD = 14;
    localparam longint QUARTER_TURN = 26353589;     // pi/2 * 2^24
    localparam longint HALF_TURN_PH = 25736;        // pi * 8192
    localparam longint GAIN_COMP = 10188014;        // 1/K * 2^24

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    typedef struct {
        bit                 drain;      // hold off until every result is back
        logic signed [15:0] px;
        logic signed [15:0] py;
    } point_req_t;

    logic clk;
    logic rst_n = 1'b0;
    logic point_valid = 1'b0;
    logic point_stall;
    logic signed [c2p_pkg::OUT_W-1:0] x_coord = '0;
    logic signed [c2p_pkg::OUT_W-1:0] y_coord = '0;
    logic polar_valid;
    logic polar_stall = 1'b0;
    logic [c2p_pkg::OUT_W-1:0] magnitude;
    logic signed [c2p_pkg::OUT_W-1:0] phase;

    point_req_t     point_backlog[$];
    c2p_pkg::res_t  polar_expected[$];
    point_req_t     next_point;
    c2p_pkg::res_t  want;
    bit             holding = 1'b0;
    int             gap_left = 0;
    int             burst_left = 1;
    int             stall_run = 0;
    stall_mode_t    stall_mode = STALL_NONE;
    int             errors = 0;

    // atan(2^-i) in radians * 2^24
    longint atan_lut [0:23] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    cartesian_to_polar u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .polar_valid (polar_valid),
        .polar_stall (polar_stall),
        .magnitude   (magnitude),
        .phase       (phase)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // CORDIC vectoring with the block's fixed-point rules
    function automatic c2p_pkg::res_t polar_of(input logic signed [15:0] xin,
                                               input logic signed [15:0] yin);
        longint        xv, yv, zv, xs, ys, tmp, ux, hi, lo, prod, mag, ph;
        c2p_pkg::res_t r;
        begin
            xv = xin;
            yv = yin;
            zv = 0;
            if (yv == 0)
            begin
                mag = (xv >= 0) ? xv : -xv;
                ph  = (xv >= 0) ? 0 : HALF_TURN_PH;
            end
            else
            begin
                // left half plane: turn by +-pi/2 first
                if (xv < 0)
                begin
                    tmp = xv;
                    if (yv >= 0)
                    begin
                        xv = yv;
                        yv = -tmp;
                        zv = QUARTER_TURN;
                    end
                    else
                    begin
                        xv = -yv;
                        yv = tmp;
                        zv = -QUARTER_TURN;
                    end
                end
                xv = xv * (64'sd1 << FRAC_GUARD);
                yv = yv * (64'sd1 << FRAC_GUARD);
                for (int i = 0; i < c2p_pkg::NUM_ROT; i++)
                begin
                    xs = xv >>> i;
                    ys = yv >>> i;
                    if (yv >= 0)
                    begin
                        xv = xv + ys;
                        yv = yv - xs;
                        zv = zv + atan_lut[i];
                    end
                    else
                    begin
                        xv = xv - ys;
                        yv = yv + xs;
                        zv = zv - atan_lut[i];
                    end
                end
                ux   = (xv > 0) ? xv : 0;
                hi   = ux >> 16;
                lo   = ux & 64'hFFFF;
                prod = hi * GAIN_COMP + ((lo * GAIN_COMP) >> 16);
                mag  = (prod + (64'sd1 << 21)) >> 22;
                ph   = (zv + 1024) >>> 11;
                if (ph > HALF_TURN_PH)
                    ph = HALF_TURN_PH;
                if (ph < -HALF_TURN_PH)
                    ph = -HALF_TURN_PH;
            end
            if (mag > 65535)
                mag = 65535;
            r.magnitude = mag[15:0];
            r.phase     = ph[15:0];
            return r;
        end
    endfunction

    function automatic int corner_value(input int pick);
        begin
            case (pick)
                0:       return -32768;
                1:       return -32767;
                2:       return -1;
                3:       return 0;
                4:       return 1;
                5:       return 32766;
                default: return 32767;
            endcase
        end
    endfunction

    task automatic add_point(input int xv, input int yv);
        point_req_t p;
        begin
            p.drain = 1'b0;
            p.px    = 16'(xv);
            p.py    = 16'(yv);
            point_backlog.push_back(p);
        end
    endtask

    task automatic add_drain();
        point_req_t p;
        begin
            p.drain = 1'b1;
            p.px    = '0;
            p.py    = '0;
            point_backlog.push_back(p);
        end
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && !holding)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                point_valid <= 1'b0;
            end
            else if (point_backlog.size() == 0)
            begin
                point_valid <= 1'b0;
            end
            else if (point_backlog[0].drain)
            begin
                point_valid <= 1'b0;
                if (polar_expected.size() == 0)
                    void'(point_backlog.pop_front());
            end
            else
            begin
                next_point = point_backlog.pop_front();
                x_coord <= next_point.px;
                y_coord <= next_point.py;
                point_valid <= 1'b1;
                holding = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver backpressure, pattern chosen anew at random intervals
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(10, 200);
        end
        else
            stall_run--;
        case (stall_mode)
            STALL_NONE:   polar_stall <= 1'b0;
            STALL_LIGHT:  polar_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  polar_stall <= ($urandom_range(0, 3) != 0);
            default:      polar_stall <= ~polar_stall;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_valid && !point_stall)
            begin
                polar_expected.push_back(polar_of(x_coord, y_coord));
                holding = 1'b0;
            end
            if (polar_valid && !polar_stall)
            begin
                if (polar_expected.size() == 0)
                begin
                    $error("unexpected transaction: magnitude %0d phase %0d",
                           magnitude, phase);
                    errors++;
                end
                else
                begin
                    want = polar_expected.pop_front();
                    if (magnitude !== want.magnitude)
                    begin
                        $error("magnitude: expected %0d, got %0d", want.magnitude, magnitude);
                        errors++;
                    end
                    if (phase !== want.phase)
                    begin
                        $error("phase: expected %0d, got %0d", want.phase, phase);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int sel;
        int rx;
        int ry;

        // axes, origin, quadrant corners, angles next to +-pi
        add_point(0, 0);
        add_point(32767, 0);
        add_point(1, 0);
        add_point(-1, 0);
        add_point(-32768, 0);
        add_point(0, 32767);
        add_point(0, -32768);
        add_point(0, 1);
        add_point(0, -1);
        add_point(32767, 32767);
        add_point(-32768, -32768);
        add_point(-32768, 32767);
        add_point(32767, -32768);
        add_point(-32768, 1);
        add_point(-32768, -1);
        add_point(-1, 1);
        add_point(-1, -1);
        add_point(1, -1);
        add_point(1, 1);
        add_point(12345, -6789);
        add_point(-20000, 15000);
        add_point(21845, -21846);
        add_point(-21846, 21845);
        add_drain();

        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            if (n == RANDOM_POINTS / 2)
                add_drain();
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                rx = int'($urandom);
                ry = int'($urandom);
            end
            else if (sel < 70)
            begin
                rx = $urandom_range(0, 32) - 16;
                ry = $urandom_range(0, 32) - 16;
            end
            else if (sel < 80)
            begin
                rx = int'($urandom);
                ry = 0;
                if ($urandom_range(0, 1) == 1)
                begin
                    ry = rx;
                    rx = 0;
                end
            end
            else if (sel < 90)
            begin
                // close to an axis, where the angle is most sensitive
                rx = int'($urandom);
                ry = $urandom_range(0, 8) - 4;
                if ($urandom_range(0, 1) == 1)
                begin
                    ry = rx;
                    rx = $urandom_range(0, 8) - 4;
                end
            end
            else
            begin
                rx = corner_value($urandom_range(0, 6));
                ry = corner_value($urandom_range(0, 6));
            end
            add_point(rx, ry);
        end

        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (point_backlog.size() != 0 || holding || polar_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
